/* rtl/fpa_pkg.sv */
// Shared types, opcodes and helper functions for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int DATA_W = 32;
    localparam int QUOT_W = 33;
    localparam int DVS_W  = 33;
    localparam int REM_W  = 66;
    localparam int PROD_W = 64;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_GT       = 4'd4;
    localparam logic [3:0] OP_LT       = 4'd5;
    localparam logic [3:0] OP_GE       = 4'd6;
    localparam logic [3:0] OP_LE       = 4'd7;
    localparam logic [3:0] OP_EQ       = 4'd8;
    localparam logic [3:0] OP_NE       = 4'd9;
    localparam logic [3:0] OP_MIN      = 4'd10;
    localparam logic [3:0] OP_MAX      = 4'd11;
    localparam logic [3:0] OP_INC      = 4'd12;
    localparam logic [3:0] OP_DEC      = 4'd13;
    localparam logic [3:0] OP_FROM_INT = 4'd14;
    localparam logic [3:0] OP_TO_INT   = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]               opcode;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     compare_true;
        logic [1:0]               status;
    } t_out_item;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [DATA_W-1:0] result;
        logic              cmp;
        logic [1:0]        status;
        logic [PROD_W-1:0] prod;
        logic [REM_W-1:0]  rem;
        logic [DVS_W-1:0]  dvs;
        logic [QUOT_W-1:0] quot;
        logic              neg;
        logic              ovf;
    } t_stage;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } t_sat;

    // Clamps a 33-bit two's complement sum to 32 bits.
    function automatic t_sat sat33(input logic [DATA_W:0] v);
        t_sat s;
        s.ovf = v[DATA_W] != v[DATA_W-1];
        s.val = s.ovf ? (v[DATA_W] ? Q_MIN : Q_MAX) : v[DATA_W-1:0];
        return s;
    endfunction

    // Applies a sign to an unsigned magnitude and clamps to 32 bits.
    function automatic t_sat sat_mag(input logic [PROD_W-1:0] m, input logic neg);
        t_sat s;
        if (neg) begin
            s.ovf = m > PROD_W'(64'h8000_0000);
            s.val = s.ovf ? Q_MIN : (~m[DATA_W-1:0] + 32'd1);
        end else begin
            s.ovf = m > PROD_W'(64'h7FFF_FFFF);
            s.val = s.ovf ? Q_MAX : m[DATA_W-1:0];
        end
        return s;
    endfunction

endpackage
`default_nettype wire

/* rtl/fixed_point_q24_8_alu_unit.sv */
// Throughput: one item per cycle while the receiver does not stall; the 33 restoring divider stages set the depth.
// Every opcode takes the same path, so results leave in input order.
// Empty stages fill under a stall, so input is taken while a result waits and any stage is still empty.
// Reset is synchronous and active low; it clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu_unit import fpa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    localparam int NSTG = QUOT_W + 3;

    logic   v   [NSTG-1];
    logic   adv [NSTG];
    t_stage stg [NSTG-1];

    // A stage loads when it is empty or the one after it moves.
    always_comb begin
        adv[NSTG-1] = !o_valid || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !v[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv[0]),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (v[0]),
        .o_stage (stg[0])
    );

    fpa_round #(.FRACTION_BITS(FRACTION_BITS)) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv[1]),
        .i_valid (v[0]),
        .i_stage (stg[0]),
        .o_valid (v[1]),
        .o_stage (stg[1])
    );

    for (genvar k = 2; k < NSTG - 1; k++) begin : g_div
        fpa_div_step #(.SHIFT(NSTG - 2 - k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv[k]),
            .i_valid (v[k-1]),
            .i_stage (stg[k-1]),
            .o_valid (v[k]),
            .o_stage (stg[k])
        );
    end

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv[NSTG-1]),
        .i_valid (v[NSTG-2]),
        .i_stage (stg[NSTG-2]),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire

/* rtl/fpa_front.sv */
// First stage: simple operations, the product and divider setup.
`timescale 1ns / 1ps
`default_nettype none
module fpa_front import fpa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_valid,
    output t_stage        o_stage
);

    logic              r_valid;
    t_stage            r_stage;
    t_stage            n_stage;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [DATA_W:0]   ea;
    logic [DATA_W:0]   eb;
    logic [DATA_W:0]   mag_a;
    logic [DATA_W:0]   mag_b;
    logic signed [PROD_W-1:0] ext;
    t_sat              s;

    always_comb begin
        a     = i_item.operand_a;
        b     = i_item.operand_b;
        ea    = {a[DATA_W-1], a};
        eb    = {b[DATA_W-1], b};
        mag_a = ea[DATA_W] ? (~ea + 1'b1) : ea;
        mag_b = eb[DATA_W] ? (~eb + 1'b1) : eb;
        ext   = PROD_W'(a) <<< FRACTION_BITS;
        s     = '{val: '0, ovf: 1'b0};

        n_stage        = '0;
        n_stage.opcode = i_item.opcode;
        // Both operands are sign-extended first so the full product is kept.
        n_stage.prod   = PROD_W'(a) * PROD_W'(b);
        // Rounded quotient is (2n + d) / (2d) with n = |a| scaled up.
        n_stage.rem    = (REM_W'(mag_a) << (FRACTION_BITS + 1)) + REM_W'(mag_b);
        n_stage.dvs    = DVS_W'(mag_b << 1);
        n_stage.neg    = a[DATA_W-1] ^ b[DATA_W-1];

        case (i_item.opcode)
            OP_ADD: s = sat33(ea + eb);
            OP_SUB: s = sat33(ea - eb);
            OP_INC: s = sat33(ea + 33'd1);
            OP_DEC: s = sat33(ea - 33'd1);
            OP_GT:  n_stage.cmp = a > b;
            OP_LT:  n_stage.cmp = a < b;
            OP_GE:  n_stage.cmp = a >= b;
            OP_LE:  n_stage.cmp = a <= b;
            OP_EQ:  n_stage.cmp = a == b;
            OP_NE:  n_stage.cmp = a != b;
            OP_MIN: s.val = (a > b) ? b : a;
            OP_MAX: s.val = (a > b) ? a : b;
            OP_FROM_INT: begin
                s.ovf = (ext > PROD_W'(64'sh7FFF_FFFF)) || (ext < -PROD_W'(64'sh8000_0000));
                s.val = s.ovf ? (a[DATA_W-1] ? Q_MIN : Q_MAX) : ext[DATA_W-1:0];
            end
            OP_TO_INT: s.val = a >>> FRACTION_BITS;
            OP_DIV: begin
                if (b == '0) begin
                    n_stage.status = ST_DIV0;
                    s.val = a[DATA_W-1] ? Q_MIN : Q_MAX;
                end
            end
            default: s = '{val: '0, ovf: 1'b0};
        endcase

        n_stage.result = s.val;
        if (s.ovf) begin
            n_stage.status = ST_OVF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

/* rtl/fpa_round.sv */
// Second stage: product rounding and the divider overflow check.
`timescale 1ns / 1ps
`default_nettype none
module fpa_round import fpa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire logic   i_valid,
    input  wire t_stage i_stage,
    output logic        o_valid,
    output t_stage      o_stage
);

    logic              r_valid;
    t_stage            r_stage;
    t_stage            n_stage;
    logic [PROD_W-1:0] pm;
    logic [PROD_W-1:0] m;
    t_sat              s;

    always_comb begin
        n_stage = i_stage;
        pm = i_stage.prod[PROD_W-1] ? (~i_stage.prod + 1'b1) : i_stage.prod;
        m  = (pm + (PROD_W'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        s  = sat_mag(m, i_stage.prod[PROD_W-1]);
        if (i_stage.opcode == OP_MUL) begin
            n_stage.result = s.val;
            n_stage.status = s.ovf ? ST_OVF : ST_OK;
        end
        // A quotient of 2^33 or more always saturates.
        n_stage.ovf = i_stage.rem[REM_W-1:QUOT_W] >= i_stage.dvs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

/* rtl/fpa_div_step.sv */
// One restoring division stage that settles a single quotient bit.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_step import fpa_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire logic   i_valid,
    input  wire t_stage i_stage,
    output logic        o_valid,
    output t_stage      o_stage
);

    logic           r_valid;
    t_stage         r_stage;
    t_stage         n_stage;
    logic [REM_W:0] trial;

    always_comb begin
        n_stage = i_stage;
        trial   = {1'b0, i_stage.rem} - ((REM_W + 1)'(i_stage.dvs) << SHIFT);
        if (i_stage.opcode == OP_DIV && !trial[REM_W]) begin
            n_stage.rem         = trial[REM_W-1:0];
            n_stage.quot[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

/* rtl/fpa_back.sv */
// Last stage: signs and clamps the quotient and holds the output item.
`timescale 1ns / 1ps
`default_nettype none
module fpa_back import fpa_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire logic   i_valid,
    input  wire t_stage i_stage,
    output logic        o_valid,
    output t_out_item   o_item
);

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;
    t_sat      s;

    always_comb begin
        s = sat_mag(PROD_W'(i_stage.quot), i_stage.neg);
        n_item.result_value = i_stage.result;
        n_item.compare_true = i_stage.cmp;
        n_item.status       = i_stage.status;
        if (i_stage.opcode == OP_DIV && i_stage.status != ST_DIV0) begin
            if (i_stage.ovf) begin
                n_item.result_value = i_stage.neg ? Q_MIN : Q_MAX;
                n_item.status       = ST_OVF;
            end else begin
                n_item.result_value = s.val;
                n_item.status       = s.ovf ? ST_OVF : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

/* rtl/fpa_checker.sv */
// Port-level checks for the fixed-point ALU and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpa_checker import fpa_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_stall,
    input wire t_in_item  i_item,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_item o_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output item changed under stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with an empty output");

    a_cmp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.compare_true |-> o_item.status == ST_OK)
        else $error("compare result with bad status");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.status == ST_OK || o_item.status == ST_OVF
                    || o_item.status == ST_DIV0)
        else $error("undefined status code");

endmodule

bind fixed_point_q24_8_alu_unit fpa_checker u_fpa_checker (.*);
`default_nettype wire

/* bench/fixed_point_q24_8_alu_unit_tb.sv */
// Self-checking testbench for the Q24.8 fixed-point ALU unit.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu_unit_tb;
    import fpa_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = 36;
    localparam int WATCHDOG_LIMIT = 4000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    fixed_point_q24_8_alu_unit #(.FRACTION_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    t_in_item  pending_ops[$];
    t_out_item expected_results[$];
    int        errors = 0;
    int        accepted_ops = 0;
    int        checked_results = 0;
    int        idle_cycles = 0;
    int        op_histogram[16];
    bit        stimulus_done = 0;
    bit        quiet_phase = 0;
    bit        hold_receiver = 0;
    bit        in_taken = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Clamps a wide signed value to 32 bits, setting the overflow status when it clamps.
    function automatic logic signed [31:0] clamp_q(input logic signed [65:0] v,
                                                   inout logic [1:0] st);
        if (v > 66'sd2147483647) begin
            st = ST_OVF;
            return Q_MAX;
        end
        if (v < -66'sd2147483648) begin
            st = ST_OVF;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic t_out_item alu_predict(input t_in_item it);
        t_out_item r;
        logic signed [65:0] a, b, p, q;
        logic [65:0] m, n, d;
        logic [1:0] st;
        logic neg;
        a = it.operand_a;
        b = it.operand_b;
        st = ST_OK;
        r.result_value = '0;
        r.compare_true = 1'b0;
        case (it.opcode)
            OP_ADD: r.result_value = clamp_q(a + b, st);
            OP_SUB: r.result_value = clamp_q(a - b, st);
            OP_MUL: begin
                p = a * b;
                m = p < 0 ? -p : p;
                m = (m + (66'd1 << (FRAC - 1))) >> FRAC;
                q = p < 0 ? -$signed(m) : $signed(m);
                r.result_value = clamp_q(q, st);
            end
            OP_DIV: begin
                if (b == 0) begin
                    st = ST_DIV0;
                    r.result_value = a < 0 ? Q_MIN : Q_MAX;
                end else begin
                    n = (a < 0 ? -a : a) << FRAC;
                    d = b < 0 ? -b : b;
                    m = (2 * n + d) / (2 * d);
                    neg = (a < 0) != (b < 0);
                    q = neg ? -$signed(m) : $signed(m);
                    r.result_value = clamp_q(q, st);
                end
            end
            OP_GT: r.compare_true = a > b;
            OP_LT: r.compare_true = a < b;
            OP_GE: r.compare_true = a >= b;
            OP_LE: r.compare_true = a <= b;
            OP_EQ: r.compare_true = a == b;
            OP_NE: r.compare_true = a != b;
            OP_MIN: r.result_value = a > b ? b : a;
            OP_MAX: r.result_value = a > b ? a : b;
            OP_INC: r.result_value = clamp_q(a + 1, st);
            OP_DEC: r.result_value = clamp_q(a - 1, st);
            OP_FROM_INT: r.result_value = clamp_q(a * (66'sd1 <<< FRAC), st);
            default: r.result_value = it.operand_a >>> FRAC;
        endcase
        r.status = st;
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 3) - 32'd1;
            3: return 32'($signed($urandom_range(0, 4096)) - 2048);
            4: return $urandom & 32'h0000_FFFF;
            5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
        t_in_item it;
        it.opcode = op;
        it.operand_a = a;
        it.operand_b = b;
        pending_ops.push_back(it);
    endtask

    // Remembers whether the offered item was taken at the last rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    // Driver: offers items from the pending queue, with random idle bursts.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // Hold the item until it is taken.
        end else begin
            if (i_valid) begin
                void'(pending_ops.pop_front());
            end
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                if (!quiet_phase && $urandom_range(0, 19) == 0) begin
                    send_gap = $urandom_range(1, 14) - 1;
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_item <= pending_ops[0];
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with an optional long hold-off.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_receiver) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: records accepted items and checks results in order.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(alu_predict(i_item));
                op_histogram[i_item.opcode] <= op_histogram[i_item.opcode] + 1;
                accepted_ops <= accepted_ops + 1;
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_item);
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    checked_results <= checked_results + 1;
                    if (o_item.result_value !== exp_r.result_value
                        || o_item.compare_true !== exp_r.compare_true
                        || o_item.status !== exp_r.status) begin
                        $display("%0t: mismatch expected val=%h cmp=%b st=%0d actual val=%h cmp=%b st=%0d",
                                 $time, exp_r.result_value, exp_r.compare_true, exp_r.status,
                                 o_item.result_value, o_item.compare_true, o_item.status);
                        errors <= errors + 1;
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no accepted item in either direction.
    always @(posedge i_clk) begin
        if (i_rst_n && !hold_receiver && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int hold_count;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item = '0;

        // Directed part: every opcode plus edge cases.
        for (int op = 0; op < 16; op++) begin
            add_op(op[3:0], 32'h7FFF_FFFF, 32'h8000_0000);
        end
        add_op(OP_DIV, 32'h0000_0100, 32'h0);
        add_op(OP_DIV, 32'h8000_0000, 32'h0);
        add_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001);
        add_op(OP_MUL, 32'h0000_0080, 32'h0000_0001);
        add_op(OP_INC, 32'h7FFF_FFFF, 32'h0);
        add_op(OP_DEC, 32'h8000_0000, 32'h0);
        add_op(OP_TO_INT, 32'hFFFF_FFFF, 32'h0);
        add_op(OP_EQ, 32'h1234_5678, 32'h1234_5678);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < 200; k++) begin
            add_op(4'($urandom), pick_operand(), pick_operand());
        end
        wait (pending_ops.size() == 0);

        // Long receiver hold-off while the sender keeps offering items.
        for (int k = 0; k < 100; k++) begin
            add_op(4'($urandom), pick_operand(), pick_operand());
        end
        @(negedge i_clk);
        hold_receiver = 1'b1;
        hold_count = 0;
        while (hold_count < 120) begin
            @(posedge i_clk);
            hold_count++;
        end
        @(negedge i_clk);
        hold_receiver = 1'b0;

        for (int k = 0; k < 400; k++) begin
            add_op(4'($urandom), pick_operand(), pick_operand());
        end
        wait (pending_ops.size() == 0);

        quiet_phase = 1'b1;
        for (int k = 0; k < 100; k++) begin
            add_op(4'($urandom), pick_operand(), pick_operand());
        end
        wait (pending_ops.size() == 0 && !i_valid);
        stimulus_done = 1'b1;
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Checked %0d results from %0d items; all 16 opcodes exercised (div count %0d).",
                 checked_results, accepted_ops, op_histogram[OP_DIV]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_round.sv
rtl/fpa_div_step.sv
rtl/fpa_back.sv
rtl/fixed_point_q24_8_alu_unit.sv
rtl/fpa_checker.sv
bench/fixed_point_q24_8_alu_unit_tb.sv
